### rtl/core/assert_macros.svh
// Assertion macros shared by the record checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/core/crc_chk_pkg.sv
// Types, constants and the CRC byte update for the record checker.
package crc_chk_pkg;

	localparam int CRC_COVERED_BYTES = 20;
	localparam int RECORD_BYTES      = 22;
	localparam int POS_W             = 5;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_VERSION     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CURVE       = POS_W'(5);
	localparam logic [POS_W-1:0] POS_MIN_END     = POS_W'(9);
	localparam logic [POS_W-1:0] POS_MAX_END     = POS_W'(13);
	localparam logic [POS_W-1:0] POS_GAMMA_END   = POS_W'(17);
	localparam logic [POS_W-1:0] POS_CALIB       = POS_W'(18);
	localparam logic [POS_W-1:0] POS_CRC_START   = POS_W'(CRC_COVERED_BYTES);
	localparam logic [POS_W-1:0] POS_LAST        = POS_W'(RECORD_BYTES - 1);

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_MAGIC   = 2'd1,
		CAUSE_VERSION = 2'd2,
		CAUSE_CRC     = 2'd3
	} cause_t;

	typedef enum logic {
		REG_MAGIC   = 1'b0,
		REG_VERSION = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
	} cfg_t;

	// One complete record as captured by the front end.
	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
		logic [7:0]  curve;
		logic [31:0] raw_min;
		logic [31:0] raw_max;
		logic [31:0] gamma;
		logic [7:0]  calib;
		logic [15:0] crc_calc;
		logic [15:0] crc_stored;
	} rec_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	// MSB-first CRC-16 update over one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

### rtl/core/crc_chk_front.sv
// Front end: takes record bytes, runs the CRC and captures the fields.
module crc_chk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                record_start,
	input  crc_chk_pkg::q_status_t q_status,
	output logic                push,
	output crc_chk_pkg::rec_t   push_rec
);

	logic [crc_chk_pkg::POS_W-1:0] pos_q;
	logic [crc_chk_pkg::POS_W-1:0] pos_cur;
	logic [15:0]                   crc_q;
	logic [15:0]                   crc_base;
	logic [15:0]                   crc_next;
	logic [31:0]                   magic_q;
	logic [7:0]                    version_q;
	logic [7:0]                    curve_q;
	logic [31:0]                   min_q;
	logic [31:0]                   max_q;
	logic [31:0]                   gamma_q;
	logic [7:0]                    calib_q;
	logic [15:0]                   stored_q;
	logic [15:0]                   stored_next;
	logic                          accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;

	// A start flag forces this byte to position zero.
	assign pos_cur  = record_start ? '0 : pos_q;
	assign crc_base = (pos_cur == '0) ? crc_chk_pkg::CRC_INIT : crc_q;
	assign crc_next = (pos_cur < crc_chk_pkg::POS_CRC_START)
		? crc_chk_pkg::crc16_byte(crc_base, data_byte) : crc_base;
	assign stored_next = {data_byte, stored_q[15:8]};

	assign push = accept && (pos_cur == crc_chk_pkg::POS_LAST);

	always_comb begin
		push_rec            = '0;
		push_rec.magic      = magic_q;
		push_rec.version    = version_q;
		push_rec.curve      = curve_q;
		push_rec.raw_min    = min_q;
		push_rec.raw_max    = max_q;
		push_rec.gamma      = gamma_q;
		push_rec.calib      = calib_q;
		push_rec.crc_calc   = crc_q;
		push_rec.crc_stored = stored_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= crc_chk_pkg::CRC_INIT;
		end else if (accept) begin
			crc_q <= crc_next;
			if (pos_cur == crc_chk_pkg::POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_cur + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_cur <= crc_chk_pkg::POS_MAGIC_END) begin
				magic_q <= {data_byte, magic_q[31:8]};
			end else if (pos_cur == crc_chk_pkg::POS_VERSION) begin
				version_q <= data_byte;
			end else if (pos_cur == crc_chk_pkg::POS_CURVE) begin
				curve_q <= data_byte;
			end else if (pos_cur <= crc_chk_pkg::POS_MIN_END) begin
				min_q <= {data_byte, min_q[31:8]};
			end else if (pos_cur <= crc_chk_pkg::POS_MAX_END) begin
				max_q <= {data_byte, max_q[31:8]};
			end else if (pos_cur <= crc_chk_pkg::POS_GAMMA_END) begin
				gamma_q <= {data_byte, gamma_q[31:8]};
			end else if (pos_cur == crc_chk_pkg::POS_CALIB) begin
				calib_q <= data_byte;
			end else if (pos_cur >= crc_chk_pkg::POS_CRC_START) begin
				stored_q <= stored_next;
			end
		end
	end

endmodule

### rtl/core/crc_chk_queue.sv
// Short record queue between the front end and the checker.
`include "assert_macros.svh"

module crc_chk_queue #(
	parameter int DEPTH = crc_chk_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  crc_chk_pkg::rec_t      push_rec,
	input  logic                   pop,
	output crc_chk_pkg::rec_t      head_rec,
	output crc_chk_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	crc_chk_pkg::rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full      = (count_q == CNT_W'(DEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign head_rec         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	`CRC_ASSERT(a_no_push_full, clk, arst_n, !(push && status.full), "push while queue full")
	`CRC_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && !status.not_empty), "pop while queue empty")
	`CRC_ASSERT_NEXT(a_count_up, clk, arst_n, (do_push && !do_pop), (count_q == $past(count_q) + 1'b1), "count did not rise on push")
endmodule

### rtl/core/crc_chk_back.sv
// Back end: compares a captured record with the registers and holds the result.
`include "assert_macros.svh"

module crc_chk_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  crc_chk_pkg::cfg_t      cfg,
	input  crc_chk_pkg::q_status_t q_status,
	input  crc_chk_pkg::rec_t      head_rec,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   record_ok,
	output logic [1:0]             fail_cause,
	output logic [7:0]             curve_code,
	output logic signed [31:0]     raw_min_value,
	output logic signed [31:0]     raw_max_value,
	output logic [31:0]            gamma_bits,
	output logic [7:0]             calibrated_byte
);

	crc_chk_pkg::cause_t cause;
	crc_chk_pkg::cause_t cause_q;
	crc_chk_pkg::rec_t   rec_q;
	logic                valid_q;

	// Checks in priority order: magic, version, stored CRC.
	always_comb begin
		if (head_rec.magic != cfg.magic) begin
			cause = crc_chk_pkg::CAUSE_MAGIC;
		end else if (head_rec.version != cfg.version) begin
			cause = crc_chk_pkg::CAUSE_VERSION;
		end else if (head_rec.crc_stored != head_rec.crc_calc) begin
			cause = crc_chk_pkg::CAUSE_CRC;
		end else begin
			cause = crc_chk_pkg::CAUSE_NONE;
		end
	end

	assign pop = q_status.not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_status.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q   <= head_rec;
			cause_q <= cause;
		end
	end

	assign out_valid       = valid_q;
	assign record_ok       = (cause_q == crc_chk_pkg::CAUSE_NONE);
	assign fail_cause      = cause_q;
	assign curve_code      = rec_q.curve;
	assign raw_min_value   = $signed(rec_q.raw_min);
	assign raw_max_value   = $signed(rec_q.raw_max);
	assign gamma_bits      = rec_q.gamma;
	assign calibrated_byte = rec_q.calib;

	`CRC_ASSERT_NEXT(a_pop_loads, clk, arst_n, pop, out_valid, "popped item not shown")
	`CRC_ASSERT_NEXT(a_idle_drain, clk, arst_n, (!q_status.not_empty && !out_stall), !out_valid, "result shown with nothing popped")
	`CRC_ASSERT(a_ok_cause, clk, arst_n, (out_valid |-> (record_ok == (fail_cause == crc_chk_pkg::CAUSE_NONE))), "ok flag disagrees with cause")
endmodule

### rtl/core/config_record_checker.sv
// After the last byte (byte 21) is queued, out_valid rises from the back end's output register.
// Throughput: one byte per cycle while in_stall is low, one result per record; the byte-wide CRC
// update is the longest path in the front end, the back end compares one record per cycle while
// out_stall is low. A queue of QUEUE_DEPTH records decouples byte intake from a stalled result.
// Reset (arst_n low, asynchronous): position, queue, output valid clear; CRC loads CRC_INIT;
// the magic and version registers (cfg_q) reset to zero.
module config_record_checker #(
	parameter int QUEUE_DEPTH = crc_chk_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               record_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               record_ok,
	output logic [1:0]         fail_cause,
	output logic [7:0]         curve_code,
	output logic signed [31:0] raw_min_value,
	output logic signed [31:0] raw_max_value,
	output logic [31:0]        gamma_bits,
	output logic [7:0]         calibrated_byte
);

	crc_chk_pkg::cfg_t       cfg_q;
	crc_chk_pkg::q_status_t  q_status;
	crc_chk_pkg::rec_t       push_rec;
	crc_chk_pkg::rec_t       head_rec;
	crc_chk_pkg::reg_idx_t   reg_idx;
	logic                    push;
	logic                    pop;
	logic                    wr_en;

	assign pready  = 1'b1;
	assign reg_idx = crc_chk_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				crc_chk_pkg::REG_MAGIC:   cfg_q.magic   <= pwdata;
				crc_chk_pkg::REG_VERSION: cfg_q.version <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			crc_chk_pkg::REG_MAGIC:   prdata = cfg_q.magic;
			crc_chk_pkg::REG_VERSION: prdata = {24'h0, cfg_q.version};
			default:                  prdata = '0;
		endcase
	end

	crc_chk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.record_start (record_start),
		.q_status     (q_status),
		.push         (push),
		.push_rec     (push_rec)
	);

	crc_chk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	crc_chk_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_status        (q_status),
		.head_rec        (head_rec),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.record_ok       (record_ok),
		.fail_cause      (fail_cause),
		.curve_code      (curve_code),
		.raw_min_value   (raw_min_value),
		.raw_max_value   (raw_max_value),
		.gamma_bits      (gamma_bits),
		.calibrated_byte (calibrated_byte)
	);

endmodule
